[sv/grid_raycast_column_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grid raycast column unit
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef GRID_RAYCAST_COLUMN_UNIT_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that is switched off while reset is applied.
`define GRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that also holds while reset is applied.
`define GRC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GRC_ASSERT(name, prop, msg)
`define GRC_ASSERT_RST(name, prop, msg)
`endif

`endif

[sv/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg
// Fixed-point widths, register map and reset values of the raycast unit.
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

  // Fixed point format.
  localparam int FRAC_BITS = 16;

  // Widths of the ray datapath.
  localparam int CAM_W   = 31;  // camera-space x, signed
  localparam int RAY_W   = 33;  // ray component, signed
  localparam int MAG_W   = 32;  // ray component magnitude
  localparam int MUL_A_W = 32;  // shared multiplier, first operand (signed)
  localparam int MUL_B_W = 19;  // shared multiplier, second operand (signed)
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes.
  localparam logic [2:0] REG_CAMERA_X     = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_VIEW_PLANE_X = 3'd4;
  localparam logic [2:0] REG_VIEW_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_SCREEN_W     = 3'd6;
  localparam logic [2:0] REG_SCREEN_H     = 3'd7;

  // Reset values.
  localparam logic [20:0] RST_CAMERA_X     = 21'd1441792;
  localparam logic [20:0] RST_CAMERA_Y     = 21'd720896;
  localparam logic [17:0] RST_VIEW_DIR_X   = 18'd196608;
  localparam logic [17:0] RST_VIEW_DIR_Y   = 18'd0;
  localparam logic [17:0] RST_VIEW_PLANE_X = 18'd0;
  localparam logic [17:0] RST_VIEW_PLANE_Y = 18'd43254;
  localparam logic [11:0] RST_SCREEN_W     = 12'd800;
  localparam logic [11:0] RST_SCREEN_H     = 12'd600;

  // Input actions.
  localparam logic ACT_MAP_WRITE = 1'b0;
  localparam logic ACT_CAST      = 1'b1;

  // Saturation values.
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [15:0] LH_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

[sv/grc_ram.sv]
// ----------------------------------------------------------------------------
// grc_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/grc_div.sv]
// ----------------------------------------------------------------------------
// grc_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_div #(
  parameter int DVW = 56,
  parameter int DSW = 40
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [DSW-1:0] divisor_i,
  output logic                done_o,
  output logic      [DVW-1:0] quotient_o,
  output logic      [DSW-1:0] remainder_o
);

  localparam int CNTW = $clog2(DVW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DVW-1:0]  quo_q, quo_d;
  logic [DSW-1:0]  rem_q, rem_d;
  logic [DSW-1:0]  dsr_q, dsr_d;
  logic [DSW:0]    trial;
  logic            fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial  = {rem_q, quo_q[DVW-1]};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(DVW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVW-2:0], fits};
      rem_d = fits ? DSW'(trial - {1'b0, dsr_q}) : trial[DSW-1:0];
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[sv/grid_raycast_column_unit.sv]
// ----------------------------------------------------------------------------
// grid_raycast_column_unit
// Casts one ray per screen column through a grid map by DDA and reports the
// wall hit, texture column, distance, line height and draw span.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                       Payload
// input     in         start & !busy                   action, column, cell
// result    out        result_valid (one cycle)        column_out .. draw_end
// config    in         psel & penable & pwrite         paddr, pwdata
//
// A map write is done in the idle state and gives no result. The time a cast
// takes is set by the shared bit-serial divider, whose dividend width DVW is
// 55 bits at the default parameters, and by the one map read per step of the
// cells walked. After reset the map is cleared at one cell a cycle, all
// MAP_SIZE * MAP_SIZE cells, with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_raycast_column_unit_defines.svh"

module grid_raycast_column_unit #(
  parameter int MAP_SIZE  = 32,
  parameter int TEX_SIZE  = 64,
  parameter int MAX_STEPS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action_i,
  input  wire logic [11:0] column_i,
  input  wire logic [4:0]  cell_x_i,
  input  wire logic [4:0]  cell_y_i,
  input  wire logic [3:0]  cell_value_i,
  // Result item
  output logic             result_valid_o,
  output logic      [11:0] column_out_o,
  output logic             no_hit_o,
  output logic             hit_side_o,
  output logic      [2:0]  texture_index_o,
  output logic      [5:0]  texture_column_o,
  output logic      [23:0] wall_distance_o,
  output logic      [15:0] line_height_o,
  output logic      [11:0] draw_start_o,
  output logic      [11:0] draw_end_o,
  // Configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [grc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [grc_pkg::DATA_W-1:0] pwdata,
  output logic      [grc_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int FB    = grc_pkg::FRAC_BITS;
  localparam int MAG_W = grc_pkg::MAG_W;
  localparam int RAY_W = grc_pkg::RAY_W;
  localparam int CAM_W = grc_pkg::CAM_W;
  localparam int MAW   = grc_pkg::MUL_A_W;
  localparam int MBW   = grc_pkg::MUL_B_W;
  localparam int MPW   = grc_pkg::MUL_P_W;
  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAP_W = $clog2(MAP_SIZE);
  localparam int CW    = ((MAP_W > 5) ? MAP_W : 5) + 2;
  localparam int STW   = $clog2(MAX_STEPS + 1);
  localparam int NW    = FB + $clog2(MAX_STEPS + 2);
  localparam int PW    = NW + MAG_W;
  localparam int DVW   = PW;
  localparam int DSW   = NW + FB;
  localparam int TXW   = $clog2(TEX_SIZE) + 1;

  // Sequencer codes.
  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_CAM_DIV   = 5'd2;
  localparam logic [4:0] S_CAM_WAIT  = 5'd3;
  localparam logic [4:0] S_RAY_X     = 5'd4;
  localparam logic [4:0] S_RAY_Y     = 5'd5;
  localparam logic [4:0] S_RAY_Y2    = 5'd6;
  localparam logic [4:0] S_SETUP     = 5'd7;
  localparam logic [4:0] S_PA_LO     = 5'd8;
  localparam logic [4:0] S_PA_HI     = 5'd9;
  localparam logic [4:0] S_PB_LO     = 5'd10;
  localparam logic [4:0] S_PB_HI     = 5'd11;
  localparam logic [4:0] S_PB_END    = 5'd12;
  localparam logic [4:0] S_STEP      = 5'd13;
  localparam logic [4:0] S_CHECK     = 5'd14;
  localparam logic [4:0] S_DIST_DIV  = 5'd15;
  localparam logic [4:0] S_DIST_WAIT = 5'd16;
  localparam logic [4:0] S_LH_DIV    = 5'd17;
  localparam logic [4:0] S_LH_WAIT   = 5'd18;
  localparam logic [4:0] S_PR_LO     = 5'd19;
  localparam logic [4:0] S_PR_HI     = 5'd20;
  localparam logic [4:0] S_PR_END    = 5'd21;
  localparam logic [4:0] S_TEX_DIV   = 5'd22;
  localparam logic [4:0] S_TEX_WAIT  = 5'd23;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [20:0] cam_x_q, cam_y_q;
  logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic        [11:0] scr_w_q, scr_h_q;
  logic               cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q   <= grc_pkg::RST_CAMERA_X;
      cam_y_q   <= grc_pkg::RST_CAMERA_Y;
      dir_x_q   <= grc_pkg::RST_VIEW_DIR_X;
      dir_y_q   <= grc_pkg::RST_VIEW_DIR_Y;
      plane_x_q <= grc_pkg::RST_VIEW_PLANE_X;
      plane_y_q <= grc_pkg::RST_VIEW_PLANE_Y;
      scr_w_q   <= grc_pkg::RST_SCREEN_W;
      scr_h_q   <= grc_pkg::RST_SCREEN_H;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        grc_pkg::REG_CAMERA_X:     cam_x_q   <= pwdata[20:0];
        grc_pkg::REG_CAMERA_Y:     cam_y_q   <= pwdata[20:0];
        grc_pkg::REG_VIEW_DIR_X:   dir_x_q   <= pwdata[17:0];
        grc_pkg::REG_VIEW_DIR_Y:   dir_y_q   <= pwdata[17:0];
        grc_pkg::REG_VIEW_PLANE_X: plane_x_q <= pwdata[17:0];
        grc_pkg::REG_VIEW_PLANE_Y: plane_y_q <= pwdata[17:0];
        grc_pkg::REG_SCREEN_W:     scr_w_q   <= pwdata[11:0];
        grc_pkg::REG_SCREEN_H:     scr_h_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[4:2])
      grc_pkg::REG_CAMERA_X:     prdata = 32'(cam_x_q);
      grc_pkg::REG_CAMERA_Y:     prdata = 32'(cam_y_q);
      grc_pkg::REG_VIEW_DIR_X:   prdata = 32'($unsigned(dir_x_q));
      grc_pkg::REG_VIEW_DIR_Y:   prdata = 32'($unsigned(dir_y_q));
      grc_pkg::REG_VIEW_PLANE_X: prdata = 32'($unsigned(plane_x_q));
      grc_pkg::REG_VIEW_PLANE_Y: prdata = 32'($unsigned(plane_y_q));
      grc_pkg::REG_SCREEN_W:     prdata = 32'(scr_w_q);
      grc_pkg::REG_SCREEN_H:     prdata = 32'(scr_h_q);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath state
  // --------------------------------------------------------------------------
  logic [4:0]              state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [STW-1:0]          steps_q, steps_d;
  logic [11:0]             col_q, col_d;
  logic signed [CAM_W-1:0] camv_q, camv_d;
  logic signed [RAY_W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [MAG_W-1:0]        ax_q, ax_d, ay_q, ay_d;
  logic [NW-1:0]           nx_q, nx_d, ny_q, ny_d, nprev_q, nprev_d;
  logic [PW-1:0]           pa_q, pa_d, pb_q, pb_d, prod_q, prod_d;
  logic signed [CW-1:0]    mx_q, mx_d, my_q, my_d;
  logic                    side_q, side_d;
  logic [3:0]              code_q, code_d;
  logic [DSW-1:0]          dist_q, dist_d;
  logic [15:0]             lh_q, lh_d;
  logic signed [MPW-1:0]   mul_q;
  logic signed [MAW-1:0]   mul_a;
  logic signed [MBW-1:0]   mul_b;

  // Result registers.
  logic        res_valid_q, res_valid_d;
  logic [11:0] res_col_q, res_col_d;
  logic        res_nohit_q, res_nohit_d;
  logic        res_side_q, res_side_d;
  logic [2:0]  res_tex_q, res_tex_d;
  logic [5:0]  res_txc_q, res_txc_d;
  logic [23:0] res_dist_q, res_dist_d;
  logic [15:0] res_lh_q, res_lh_d;
  logic [11:0] res_ds_q, res_ds_d;
  logic [11:0] res_de_q, res_de_d;

  // Map memory ports and divider ports.
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [3:0]     ram_wdata, ram_rdata;
  logic           div_start, div_done;
  logic [DVW-1:0] div_dvd, div_quo;
  logic [DSW-1:0] div_dsr, div_rem;

  grc_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  grc_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign busy = (state_q != S_IDLE);

  // Helper values for the walk and the final stage.
  logic                 x_step;
  logic signed [CW-1:0] mx_n, my_n;
  logic                 out_of_grid;
  logic [MAG_W-1:0]     a_sel, a_div, o_mag;
  logic [15:0]          px_frac, py_frac;
  logic [15:0]          off_lo, wall_lo;
  logic [FB+TXW-1:0]    tx_prod;
  logic [TXW-1:0]       tx, tx_m;
  logic                 mirror, o_neg, rem_nz;
  logic [10:0]          h_half;
  logic [14:0]          l_half;
  logic [16:0]          de_sum;

  assign px_frac = cam_x_q[FB-1:0];
  assign py_frac = cam_y_q[FB-1:0];

  always_comb begin
    x_step      = pa_q < pb_q;
    mx_n        = x_step ? (rx_q[RAY_W-1] ? mx_q - CW'(1) : mx_q + CW'(1)) : mx_q;
    my_n        = x_step ? my_q : (ry_q[RAY_W-1] ? my_q - CW'(1) : my_q + CW'(1));
    out_of_grid = (mx_n < 0) || (mx_n >= CW'(MAP_SIZE)) ||
                  (my_n < 0) || (my_n >= CW'(MAP_SIZE));
    a_sel       = side_q ? ay_q : ax_q;
    a_div       = (a_sel == '0) ? MAG_W'(1) : a_sel;
    o_mag       = side_q ? ax_q : ay_q;
    o_neg       = side_q ? rx_q[RAY_W-1] : ry_q[RAY_W-1];
    // Texture coordinate from the quotient and remainder of the hit offset.
    rem_nz      = div_rem != '0;
    off_lo      = o_neg ? 16'(-(div_quo[15:0] + 16'(rem_nz))) : div_quo[15:0];
    wall_lo     = (side_q ? px_frac : py_frac) + off_lo;
    tx_prod     = (FB+TXW)'(wall_lo) * (FB+TXW)'(TEX_SIZE);
    tx          = tx_prod[FB+TXW-1:FB];
    mirror      = (!side_q && !rx_q[RAY_W-1] && (rx_q != '0)) ||
                  (side_q && ry_q[RAY_W-1]);
    tx_m        = mirror ? TXW'(TEX_SIZE - 1) - tx : tx;
    // Draw span.
    h_half      = scr_h_q[11:1];
    l_half      = lh_q[15:1];
    de_sum      = 17'(l_half) + 17'(h_half);
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_RAY_X: begin
        mul_a = MAW'(camv_q);
        mul_b = MBW'(plane_x_q);
      end
      S_RAY_Y: begin
        mul_a = MAW'(camv_q);
        mul_b = MBW'(plane_y_q);
      end
      S_PA_LO: begin
        mul_a = MAW'(nx_q);
        mul_b = MBW'(ay_q[15:0]);
      end
      S_PA_HI: begin
        mul_a = MAW'(nx_q);
        mul_b = MBW'(ay_q[31:16]);
      end
      S_PB_LO: begin
        mul_a = MAW'(ny_q);
        mul_b = MBW'(ax_q[15:0]);
      end
      S_PB_HI: begin
        mul_a = MAW'(ny_q);
        mul_b = MBW'(ax_q[31:16]);
      end
      S_PR_LO: begin
        mul_a = MAW'(nprev_q);
        mul_b = MBW'(o_mag[15:0]);
      end
      S_PR_HI: begin
        mul_a = MAW'(nprev_q);
        mul_b = MBW'(o_mag[31:16]);
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    steps_d     = steps_q;
    col_d       = col_q;
    camv_d      = camv_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    nprev_d     = nprev_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    prod_d      = prod_q;
    mx_d        = mx_q;
    my_d        = my_q;
    side_d      = side_q;
    code_d      = code_q;
    dist_d      = dist_q;
    lh_d        = lh_q;
    res_valid_d = 1'b0;
    res_col_d   = res_col_q;
    res_nohit_d = res_nohit_q;
    res_side_d  = res_side_q;
    res_tex_d   = res_tex_q;
    res_txc_d   = res_txc_q;
    res_dist_d  = res_dist_q;
    res_lh_d    = res_lh_q;
    res_ds_d    = res_ds_q;
    res_de_d    = res_de_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(int'(cell_x_i) * MAP_SIZE + int'(cell_y_i));
    ram_wdata   = cell_value_i;
    ram_raddr   = AW'(int'($unsigned(mx_n)) * MAP_SIZE + int'($unsigned(my_n)));
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dsr     = DSW'(1);

    unique case (state_q)
      // Zero the map, one cell a cycle.
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (action_i == grc_pkg::ACT_MAP_WRITE) begin
            ram_we = (int'(cell_x_i) < MAP_SIZE) && (int'(cell_y_i) < MAP_SIZE);
          end else begin
            col_d   = column_i;
            state_d = S_CAM_DIV;
          end
        end
      end
      // Camera-space x of the column.
      S_CAM_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVW'({col_q, 1'b0, {FB{1'b0}}});
        div_dsr   = DSW'((scr_w_q == '0) ? 12'd1 : scr_w_q);
        state_d   = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        if (div_done) begin
          camv_d  = $signed({2'b00, div_quo[CAM_W-3:0]}) - $signed(CAM_W'(1 << FB));
          state_d = S_RAY_X;
        end
      end
      S_RAY_X: begin
        state_d = S_RAY_Y;
      end
      S_RAY_Y: begin
        rx_d    = $signed(mul_q[FB+RAY_W-1:FB]) + RAY_W'(dir_x_q);
        state_d = S_RAY_Y2;
      end
      S_RAY_Y2: begin
        ry_d    = $signed(mul_q[FB+RAY_W-1:FB]) + RAY_W'(dir_y_q);
        state_d = S_SETUP;
      end
      // Start cell, ray magnitudes and first boundary numerators.
      S_SETUP: begin
        ax_d    = MAG_W'(rx_q[RAY_W-1] ? -rx_q : rx_q);
        ay_d    = MAG_W'(ry_q[RAY_W-1] ? -ry_q : ry_q);
        mx_d    = CW'(cam_x_q[20:FB]);
        my_d    = CW'(cam_y_q[20:FB]);
        nx_d    = rx_q[RAY_W-1] ? NW'(px_frac) : NW'(17'h10000 - 17'(px_frac));
        ny_d    = ry_q[RAY_W-1] ? NW'(py_frac) : NW'(17'h10000 - 17'(py_frac));
        steps_d = '0;
        side_d  = 1'b0;
        if ((rx_q == '0) && (ry_q == '0)) begin
          res_valid_d = 1'b1;
          res_col_d   = col_q;
          res_nohit_d = 1'b1;
          res_side_d  = 1'b0;
          res_tex_d   = '0;
          res_txc_d   = '0;
          res_dist_d  = grc_pkg::DIST_MAX;
          res_lh_d    = '0;
          res_ds_d    = '0;
          res_de_d    = '0;
          state_d     = S_IDLE;
        end else begin
          state_d = S_PA_LO;
        end
      end
      S_PA_LO: begin
        state_d = S_PA_HI;
      end
      S_PA_HI: begin
        pa_d    = PW'($unsigned(mul_q));
        state_d = S_PB_LO;
      end
      S_PB_LO: begin
        pa_d    = pa_q + (PW'($unsigned(mul_q)) << 16);
        state_d = S_PB_HI;
      end
      S_PB_HI: begin
        pb_d    = PW'($unsigned(mul_q));
        state_d = S_PB_END;
      end
      S_PB_END: begin
        pb_d    = pb_q + (PW'($unsigned(mul_q)) << 16);
        state_d = S_STEP;
      end
      // One DDA step: pick the nearer boundary and read the new cell.
      S_STEP: begin
        if (steps_q == STW'(MAX_STEPS)) begin
          res_valid_d = 1'b1;
          res_col_d   = col_q;
          res_nohit_d = 1'b1;
          res_side_d  = 1'b0;
          res_tex_d   = '0;
          res_txc_d   = '0;
          res_dist_d  = grc_pkg::DIST_MAX;
          res_lh_d    = '0;
          res_ds_d    = '0;
          res_de_d    = '0;
          state_d     = S_IDLE;
        end else begin
          steps_d = steps_q + STW'(1);
          mx_d    = mx_n;
          my_d    = my_n;
          side_d  = !x_step;
          if (x_step) begin
            nprev_d = nx_q;
            nx_d    = nx_q + NW'(1 << FB);
            pa_d    = pa_q + (PW'(ay_q) << FB);
          end else begin
            nprev_d = ny_q;
            ny_d    = ny_q + NW'(1 << FB);
            pb_d    = pb_q + (PW'(ax_q) << FB);
          end
          if (out_of_grid) begin
            res_valid_d = 1'b1;
            res_col_d   = col_q;
            res_nohit_d = 1'b1;
            res_side_d  = 1'b0;
            res_tex_d   = '0;
            res_txc_d   = '0;
            res_dist_d  = grc_pkg::DIST_MAX;
            res_lh_d    = '0;
            res_ds_d    = '0;
            res_de_d    = '0;
            state_d     = S_IDLE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        code_d  = ram_rdata;
        state_d = (ram_rdata != '0) ? S_DIST_DIV : S_STEP;
      end
      // Perpendicular distance.
      S_DIST_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVW'(nprev_q) << FB;
        div_dsr   = DSW'(a_div);
        state_d   = S_DIST_WAIT;
      end
      S_DIST_WAIT: begin
        if (div_done) begin
          dist_d = div_quo[DSW-1:0];
          if (div_quo[DSW-1:0] == '0) begin
            lh_d    = (scr_h_q == '0) ? 16'd0 : grc_pkg::LH_MAX;
            state_d = S_PR_LO;
          end else begin
            state_d = S_LH_DIV;
          end
        end
      end
      // Line height.
      S_LH_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVW'(scr_h_q) << FB;
        div_dsr   = dist_q;
        state_d   = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        if (div_done) begin
          lh_d    = (div_quo[DVW-1:16] != '0) ? grc_pkg::LH_MAX : div_quo[15:0];
          state_d = S_PR_LO;
        end
      end
      // Hit offset along the wall.
      S_PR_LO: begin
        state_d = S_PR_HI;
      end
      S_PR_HI: begin
        prod_d  = PW'($unsigned(mul_q));
        state_d = S_PR_END;
      end
      S_PR_END: begin
        prod_d  = prod_q + (PW'($unsigned(mul_q)) << 16);
        state_d = S_TEX_DIV;
      end
      S_TEX_DIV: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dsr   = DSW'(a_div);
        state_d   = S_TEX_WAIT;
      end
      S_TEX_WAIT: begin
        if (div_done) begin
          res_valid_d = 1'b1;
          res_col_d   = col_q;
          res_nohit_d = 1'b0;
          res_side_d  = side_q;
          res_tex_d   = 3'(code_q - 4'd1);
          res_txc_d   = 6'(tx_m);
          res_dist_d  = (dist_q > DSW'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX
                                                            : dist_q[23:0];
          res_lh_d    = lh_q;
          res_ds_d    = (15'(h_half) > l_half) ? 12'(15'(h_half) - l_half) : 12'd0;
          res_de_d    = (de_sum >= 17'(scr_h_q))
                        ? ((scr_h_q == '0) ? 12'd0 : scr_h_q - 12'd1)
                        : de_sum[11:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      steps_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      steps_q     <= steps_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk_i) begin
    mul_q       <= mul_a * mul_b;
    col_q       <= col_d;
    camv_q      <= camv_d;
    rx_q        <= rx_d;
    ry_q        <= ry_d;
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    nx_q        <= nx_d;
    ny_q        <= ny_d;
    nprev_q     <= nprev_d;
    pa_q        <= pa_d;
    pb_q        <= pb_d;
    prod_q      <= prod_d;
    mx_q        <= mx_d;
    my_q        <= my_d;
    side_q      <= side_d;
    code_q      <= code_d;
    dist_q      <= dist_d;
    lh_q        <= lh_d;
    res_col_q   <= res_col_d;
    res_nohit_q <= res_nohit_d;
    res_side_q  <= res_side_d;
    res_tex_q   <= res_tex_d;
    res_txc_q   <= res_txc_d;
    res_dist_q  <= res_dist_d;
    res_lh_q    <= res_lh_d;
    res_ds_q    <= res_ds_d;
    res_de_q    <= res_de_d;
  end

  assign result_valid_o   = res_valid_q;
  assign column_out_o     = res_col_q;
  assign no_hit_o         = res_nohit_q;
  assign hit_side_o       = res_side_q;
  assign texture_index_o  = res_tex_q;
  assign texture_column_o = res_txc_q;
  assign wall_distance_o  = res_dist_q;
  assign line_height_o    = res_lh_q;
  assign draw_start_o     = res_ds_q;
  assign draw_end_o       = res_de_q;

  // Assertions.
  `GRC_ASSERT(a_result_when_idle, result_valid_o |-> !busy, "result while busy")
  `GRC_ASSERT(a_map_write_no_result, (start && !busy && action_i == grc_pkg::ACT_MAP_WRITE) |=> !result_valid_o, "map write gave a result")
  `GRC_ASSERT(a_no_hit_fields, (result_valid_o && no_hit_o) |-> (wall_distance_o == grc_pkg::DIST_MAX && line_height_o == 16'd0), "bad no-hit result")
  `GRC_ASSERT(a_single_result, result_valid_o |=> !result_valid_o, "results back to back")
  `GRC_ASSERT_RST(a_clear_after_reset, !rst_ni |=> busy, "map clear not busy")

endmodule

`default_nettype wire

[tb/sv/grid_raycast_column_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_raycast_column_checker
// Watches the item, result and register channels of the raycast unit. It
// keeps its own copy of the map and registers, predicts each cast by an
// exact fixed-point DDA walk and compares every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_raycast_column_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        action_i,
  input  wire logic [11:0] column_i,
  input  wire logic [4:0]  cell_x_i,
  input  wire logic [4:0]  cell_y_i,
  input  wire logic [3:0]  cell_value_i,
  input  wire logic        result_valid_i,
  input  wire logic [11:0] column_out_i,
  input  wire logic        no_hit_i,
  input  wire logic        hit_side_i,
  input  wire logic [2:0]  texture_index_i,
  input  wire logic [5:0]  texture_column_i,
  input  wire logic [23:0] wall_distance_i,
  input  wire logic [15:0] line_height_i,
  input  wire logic [11:0] draw_start_i,
  input  wire logic [11:0] draw_end_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic        pready_i,
  output int               mismatch_count_o,
  output int               pending_count_o,
  output int               wall_hits_o,
  output int               misses_o
);

  localparam int  GRID   = 32;
  localparam int  TEX    = 64;
  localparam int  STEPS  = 64;
  localparam int  FB     = grc_pkg::FRAC_BITS;
  localparam longint ONE = 64'sd1 << FB;

  typedef struct packed {
    logic [11:0] column;
    logic        no_hit;
    logic        side;
    logic [2:0]  tex_index;
    logic [5:0]  tex_column;
    logic [23:0] distance;
    logic [15:0] height;
    logic [11:0] span_start;
    logic [11:0] span_end;
  } wall_slice_t;

  logic [20:0] cam_x_q, cam_y_q;
  logic [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [11:0] screen_w_q, screen_h_q;
  logic [3:0]  map_q [GRID][GRID];
  wall_slice_t expected_slices [$];

  // Exact DDA walk for one screen column against the current map.
  function automatic wall_slice_t cast_column(logic [11:0] col);
    wall_slice_t s;
    longint unsigned w, h, ax, ay, nx, ny, nprev, a, perp, lh, prod, q, r, tx;
    longint px, py, cam, rx, ry, mx, my, sx, sy, o, off, ds, de, wall;
    int side;
    bit hit;
    logic [3:0] code;
    s = '{default: '0};
    s.column = col;
    side = 0;
    hit = 0;
    code = '0;
    nprev = 0;
    w = (screen_w_q == 0) ? 1 : screen_w_q;
    h = screen_h_q;
    px = cam_x_q;
    py = cam_y_q;
    cam = longint'(((longint'(col) * 2) << FB) / w) - ONE;
    rx = longint'($signed(dir_x_q)) + ((longint'($signed(plane_x_q)) * cam) >>> FB);
    ry = longint'($signed(dir_y_q)) + ((longint'($signed(plane_y_q)) * cam) >>> FB);
    if (rx != 0 || ry != 0) begin
      ax = (rx < 0) ? -rx : rx;
      ay = (ry < 0) ? -ry : ry;
      mx = px >>> FB;
      my = py >>> FB;
      sx = (rx < 0) ? -1 : 1;
      sy = (ry < 0) ? -1 : 1;
      nx = (rx < 0) ? (px & (ONE - 1)) : ONE - (px & (ONE - 1));
      ny = (ry < 0) ? (py & (ONE - 1)) : ONE - (py & (ONE - 1));
      for (int i = 0; i < STEPS; i++) begin
        // Step across whichever boundary is nearer; ties go along y.
        if (nx * ay < ny * ax) begin
          nprev = nx;
          nx += ONE;
          mx += sx;
          side = 0;
        end else begin
          nprev = ny;
          ny += ONE;
          my += sy;
          side = 1;
        end
        if (mx < 0 || mx >= GRID || my < 0 || my >= GRID) break;
        code = map_q[mx][my];
        if (code != 0) begin
          hit = 1;
          break;
        end
      end
    end
    if (!hit) begin
      s.no_hit = 1'b1;
      s.distance = grc_pkg::DIST_MAX;
      return s;
    end
    a = side ? ay : ax;
    if (a == 0) a = 1;
    perp = (nprev << FB) / a;
    if (perp == 0) lh = 65535;
    else begin
      lh = (h << FB) / perp;
      if (lh > 65535) lh = 65535;
    end
    if (h == 0) lh = 0;
    ds = longint'(h / 2) - longint'(lh / 2);
    if (ds < 0) ds = 0;
    de = longint'(lh / 2) + longint'(h / 2);
    if (de >= longint'(h)) de = (h != 0) ? longint'(h) - 1 : 0;
    // Texture column from the hit point along the other axis.
    o = side ? rx : ry;
    prod = nprev * ((o < 0) ? -o : o);
    q = prod / a;
    r = prod % a;
    off = (o < 0) ? -longint'(q + (r != 0)) : longint'(q);
    wall = (side ? px : py) + off;
    tx = ((wall & (ONE - 1)) * TEX) >> FB;
    if ((side == 0 && rx > 0) || (side == 1 && ry < 0)) tx = TEX - 1 - tx;
    s.side = side[0];
    s.tex_index = 3'(code - 4'd1);
    s.tex_column = tx[5:0];
    s.distance = (perp > 64'hFFFFFF) ? grc_pkg::DIST_MAX : perp[23:0];
    s.height = lh[15:0];
    s.span_start = ds[11:0];
    s.span_end = de[11:0];
    return s;
  endfunction

  assign pending_count_o = expected_slices.size();

  always @(posedge clk_i or negedge rst_ni) begin
    wall_slice_t want, got;
    if (!rst_ni) begin
      cam_x_q <= grc_pkg::RST_CAMERA_X;
      cam_y_q <= grc_pkg::RST_CAMERA_Y;
      dir_x_q <= grc_pkg::RST_VIEW_DIR_X;
      dir_y_q <= grc_pkg::RST_VIEW_DIR_Y;
      plane_x_q <= grc_pkg::RST_VIEW_PLANE_X;
      plane_y_q <= grc_pkg::RST_VIEW_PLANE_Y;
      screen_w_q <= grc_pkg::RST_SCREEN_W;
      screen_h_q <= grc_pkg::RST_SCREEN_H;
      for (int x = 0; x < GRID; x++)
        for (int y = 0; y < GRID; y++) map_q[x][y] <= '0;
      expected_slices.delete();
      mismatch_count_o <= 0;
      wall_hits_o <= 0;
      misses_o <= 0;
    end else begin
      // Register writes land at the access phase.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          grc_pkg::REG_CAMERA_X:     cam_x_q <= pwdata_i[20:0];
          grc_pkg::REG_CAMERA_Y:     cam_y_q <= pwdata_i[20:0];
          grc_pkg::REG_VIEW_DIR_X:   dir_x_q <= pwdata_i[17:0];
          grc_pkg::REG_VIEW_DIR_Y:   dir_y_q <= pwdata_i[17:0];
          grc_pkg::REG_VIEW_PLANE_X: plane_x_q <= pwdata_i[17:0];
          grc_pkg::REG_VIEW_PLANE_Y: plane_y_q <= pwdata_i[17:0];
          grc_pkg::REG_SCREEN_W:     screen_w_q <= pwdata_i[11:0];
          grc_pkg::REG_SCREEN_H:     screen_h_q <= pwdata_i[11:0];
          default: ;
        endcase
      end
      // Accepted item: map writes update the map, casts queue a prediction.
      if (start_i && !busy_i) begin
        if (action_i == grc_pkg::ACT_MAP_WRITE) map_q[cell_x_i][cell_y_i] <= cell_value_i;
        else expected_slices.push_back(cast_column(column_i));
      end
      // Each result is compared with the oldest prediction.
      if (result_valid_i) begin
        got = '{column_out_i, no_hit_i, hit_side_i, texture_index_i, texture_column_i,
                wall_distance_i, line_height_i, draw_start_i, draw_end_i};
        if (expected_slices.size() == 0) begin
          mismatch_count_o <= mismatch_count_o + 1;
          if (mismatch_count_o < 10)
            $display("ERROR: unexpected result for column %0d", column_out_i);
        end else begin
          want = expected_slices.pop_front();
          if (got.no_hit) misses_o <= misses_o + 1;
          else wall_hits_o <= wall_hits_o + 1;
          if (got != want) begin
            mismatch_count_o <= mismatch_count_o + 1;
            if (mismatch_count_o < 10) begin
              $display("ERROR: col/nohit/side/tex/tcol/dist/lh/ds/de exp %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                       want.column, want.no_hit, want.side, want.tex_index, want.tex_column,
                       want.distance, want.height, want.span_start, want.span_end);
              $display("       got %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                       got.column, got.no_hit, got.side, got.tex_index, got.tex_column,
                       got.distance, got.height, got.span_start, got.span_end);
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_grid_raycast_column_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_raycast_column_unit
// Drives map writes, casts and register settings into the raycast unit with
// random gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_raycast_column_unit;

  localparam int ITEMS_PER_PHASE = 130;
  localparam int PHASES          = 10;
  localparam int SETTLE_CYCLES   = 500;
  localparam int CYCLE_LIMIT     = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = grc_pkg::ACT_MAP_WRITE;
  logic [11:0] column_i = '0;
  logic [4:0]  cell_x_i = '0, cell_y_i = '0;
  logic [3:0]  cell_value_i = '0;
  logic        result_valid_o, no_hit_o, hit_side_o;
  logic [11:0] column_out_o, draw_start_o, draw_end_o;
  logic [2:0]  texture_index_o;
  logic [5:0]  texture_column_o;
  logic [23:0] wall_distance_o;
  logic [15:0] line_height_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [grc_pkg::ADDR_W-1:0] paddr = '0;
  logic [grc_pkg::DATA_W-1:0] pwdata = '0;
  logic [grc_pkg::DATA_W-1:0] prdata;
  logic        pready;
  int          mismatches, pending, wall_hits, misses;
  int          cycle_count = 0;

  always #5 clk_i = ~clk_i;

  grid_raycast_column_unit dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .column_i, .cell_x_i, .cell_y_i,
    .cell_value_i, .result_valid_o, .column_out_o, .no_hit_o, .hit_side_o,
    .texture_index_o, .texture_column_o, .wall_distance_o, .line_height_o,
    .draw_start_o, .draw_end_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  grid_raycast_column_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .action_i, .column_i,
    .cell_x_i, .cell_y_i, .cell_value_i, .result_valid_i(result_valid_o),
    .column_out_i(column_out_o), .no_hit_i(no_hit_o), .hit_side_i(hit_side_o),
    .texture_index_i(texture_index_o), .texture_column_i(texture_column_o),
    .wall_distance_i(wall_distance_o), .line_height_i(line_height_o),
    .draw_start_i(draw_start_o), .draw_end_i(draw_end_o), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .pready_i(pready), .mismatch_count_o(mismatches), .pending_count_o(pending),
    .wall_hits_o(wall_hits), .misses_o(misses)
  );

  // Watchdog for a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one item at the current falling edge and hold it until accepted.
  // Returns at the falling edge after acceptance with start still high.
  task automatic send_item(logic act, logic [11:0] col, logic [4:0] cx, logic [4:0] cy,
                           logic [3:0] code);
    start = 1'b1;
    action_i = act;
    column_i = col;
    cell_x_i = cx;
    cell_y_i = cy;
    cell_value_i = code;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Let every cast finish before touching the registers.
  task automatic drain_casts();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_item();
    logic [11:0] col;
    col = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 900));
    if ($urandom_range(0, 9) < 3)
      send_item(grc_pkg::ACT_MAP_WRITE, 12'($urandom), 5'($urandom), 5'($urandom),
                4'($urandom));
    else
      send_item(grc_pkg::ACT_CAST, col, 5'($urandom), 5'($urandom), 4'($urandom));
  endtask

  task automatic load_settings(int phase);
    logic [31:0] v [8];
    // Extremes first, then one fully random set, then random views from inside the map.
    case (phase)
      1: foreach (v[i]) v[i] = 32'hFFFF_FFFF;
      2: v = '{32'd0, 32'd0, 32'h20000, 32'h20000, 32'h20000, 32'h20000, 32'd0, 32'd0};
      3: v = '{32'd1441792, 32'd720896, 32'd0, 32'd0, 32'd0, 32'd0, 32'd800, 32'd600};
      4: v = '{32'd1000000, 32'd1000000, 32'h3FFFF & -32'd65536, 32'd0, 32'd0, 32'd0,
               32'd320, 32'd4095};
      5: foreach (v[i]) v[i] = $urandom;
      default: begin
        v[0] = $urandom_range(65536, 31 * 65536);
        v[1] = $urandom_range(65536, 31 * 65536);
        for (int i = 2; i < 6; i++) v[i] = 32'($urandom_range(0, 262143));
        v[6] = $urandom_range(1, 4095);
        v[7] = $urandom_range(1, 4095);
      end
    endcase
    write_register(grc_pkg::REG_CAMERA_X, v[0]);
    write_register(grc_pkg::REG_CAMERA_Y, v[1]);
    write_register(grc_pkg::REG_VIEW_DIR_X, v[2]);
    write_register(grc_pkg::REG_VIEW_DIR_Y, v[3]);
    write_register(grc_pkg::REG_VIEW_PLANE_X, v[4]);
    write_register(grc_pkg::REG_VIEW_PLANE_Y, v[5]);
    write_register(grc_pkg::REG_SCREEN_W, v[6]);
    write_register(grc_pkg::REG_SCREEN_H, v[7]);
  endtask

  initial begin
    int idle;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: walls around the default camera, code extremes, column extremes.
    send_item(grc_pkg::ACT_CAST, 12'd400, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'd0, 5'd20, 5'd11, 4'd1);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'd0, 5'd21, 5'd12, 4'd8);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'd0, 5'd31, 5'd31, 4'd15);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'hFFF, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_CAST, 12'd0, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_CAST, 12'd400, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_CAST, 12'd799, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_CAST, 12'hFFF, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'd0, 5'd18, 5'd11, 4'd9);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'd0, 5'd20, 5'd11, 4'd0);
    send_item(grc_pkg::ACT_CAST, 12'd400, 5'd0, 5'd0, 4'd0);
    send_item(grc_pkg::ACT_MAP_WRITE, 12'd0, 5'd18, 5'd11, 4'd0);
    send_item(grc_pkg::ACT_CAST, 12'd400, 5'd0, 5'd0, 4'd0);

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain_casts();
        load_settings(phase);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_item();
        if (phase < PHASES - 2 && $urandom_range(0, 3) == 0) begin
          idle = $urandom_range(1, 11);
          start = 1'b0;
          repeat (idle) @(negedge clk_i);
        end
      end
    end

    drain_casts();
    $display("Covered %0d wall hits and %0d misses over %0d register settings.",
             wall_hits, misses, PHASES);
    if (mismatches == 0) $display("CHECK OK");
    else begin
      $display("%0d mismatching results", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
